// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define BDAR_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define BDAR_ASSERT(label, prop, msg) \
    `BDAR_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== hdl/bdar_pkg.sv =====
// ----------------------------------------------------------------------------
// bdar_pkg
// Types and constants shared by the button debounce and auto-repeat unit.
// ----------------------------------------------------------------------------
package bdar_pkg;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PERIOD_W   = 8;
    localparam int CFG_TIME_W = 16;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_ENABLE = 3'd4;

    // Register values after reset.
    localparam logic [PERIOD_W-1:0]   RST_SAMPLE_PERIOD = 8'd5;
    localparam logic [CFG_TIME_W-1:0] RST_DEBOUNCE      = 16'd30;
    localparam logic [CFG_TIME_W-1:0] RST_HOLD          = 16'd600;
    localparam logic [CFG_TIME_W-1:0] RST_REPEAT        = 16'd150;

    // Timing registers seen by the button cells.
    typedef struct packed {
        logic [PERIOD_W-1:0]   sample_period;
        logic [CFG_TIME_W-1:0] debounce;
        logic [CFG_TIME_W-1:0] hold;
        logic [CFG_TIME_W-1:0] repeat_ival;
    } t_cfg;

    // Sampling status for the item in the input register.
    typedef struct packed {
        logic                sample;
        logic [PERIOD_W-1:0] elapsed;
    } t_tick;

endpackage

// ===== hdl/bdar_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bdar_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module bdar_cfg_regs #(
    parameter int BUTTONS = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [bdar_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [bdar_pkg::CFG_DATA_W-1:0] i_data,
    output bdar_pkg::t_cfg                 o_cfg,
    output logic [BUTTONS-1:0]             o_repeat_enable
);
    import bdar_pkg::*;

    t_cfg               r_cfg;
    logic [BUTTONS-1:0] r_repeat_enable;

    // Each transaction writes one register; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_period <= RST_SAMPLE_PERIOD;
            r_cfg.debounce      <= RST_DEBOUNCE;
            r_cfg.hold          <= RST_HOLD;
            r_cfg.repeat_ival   <= RST_REPEAT;
            r_repeat_enable     <= '0;
        end else if (i_wr_en) begin
            unique case (i_index)
                REG_SAMPLE_PERIOD: r_cfg.sample_period <= i_data[PERIOD_W-1:0];
                REG_DEBOUNCE:      r_cfg.debounce      <= i_data[CFG_TIME_W-1:0];
                REG_HOLD:          r_cfg.hold          <= i_data[CFG_TIME_W-1:0];
                REG_REPEAT:        r_cfg.repeat_ival   <= i_data[CFG_TIME_W-1:0];
                REG_REPEAT_ENABLE: r_repeat_enable     <= i_data[BUTTONS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg           = r_cfg;
    assign o_repeat_enable = r_repeat_enable;

endmodule

// ===== hdl/bdar_sampler.sv =====
// ----------------------------------------------------------------------------
// bdar_sampler
// Tick counter that decides which items are sampling ticks.
// ----------------------------------------------------------------------------
module bdar_sampler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [bdar_pkg::PERIOD_W-1:0] i_period,
    output bdar_pkg::t_tick              o_tick
);
    import bdar_pkg::*;

    localparam logic [PERIOD_W-1:0] ELAPSED_MAX = '1;

    logic [PERIOD_W-1:0] r_elapsed;
    logic [PERIOD_W-1:0] n_elapsed;
    logic [PERIOD_W-1:0] w_count;
    logic                w_sample;

    // Ticks since the last sampling, including this one, saturating.
    always_comb begin
        w_count   = (r_elapsed == ELAPSED_MAX) ? ELAPSED_MAX : r_elapsed + 1'b1;
        w_sample  = (w_count >= i_period);
        n_elapsed = w_sample ? '0 : w_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
        end else if (i_step) begin
            r_elapsed <= n_elapsed;
        end
    end

    assign o_tick.sample  = w_sample;
    assign o_tick.elapsed = w_count;

endmodule

// ===== hdl/bdar_button.sv =====
// ----------------------------------------------------------------------------
// bdar_button
// Per-button press tracker: debounce, first click and auto-repeat clicks.
// ----------------------------------------------------------------------------
module bdar_button #(
    parameter int TIME_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic                         i_pressed,
    input  logic [bdar_pkg::PERIOD_W-1:0] i_elapsed,
    input  bdar_pkg::t_cfg               i_cfg,
    input  logic                         i_repeat_en,
    output logic                         o_click
);
    import bdar_pkg::*;

    localparam int CMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic                 r_pressed;
    logic                 r_counted;
    logic [TIME_BITS-1:0] r_held;
    logic [TIME_BITS-1:0] r_since;
    logic                 n_pressed;
    logic                 n_counted;
    logic [TIME_BITS-1:0] n_held;
    logic [TIME_BITS-1:0] n_since;
    logic [TIME_BITS:0]   w_held_sum;
    logic [TIME_BITS:0]   w_since_sum;
    logic [TIME_BITS-1:0] w_held;
    logic [TIME_BITS-1:0] w_since;
    logic                 w_counted;
    logic                 w_first;
    logic                 w_repeat;

    // Press timers grow by the ticks since the previous sampling, saturating.
    always_comb begin
        w_held_sum  = {1'b0, r_held}  + (TIME_BITS+1)'(i_elapsed);
        w_since_sum = {1'b0, r_since} + (TIME_BITS+1)'(i_elapsed);
        if (r_pressed) begin
            w_held    = w_held_sum[TIME_BITS]  ? TIME_MAX : w_held_sum[TIME_BITS-1:0];
            w_since   = w_since_sum[TIME_BITS] ? TIME_MAX : w_since_sum[TIME_BITS-1:0];
            w_counted = r_counted;
        end else begin
            w_held    = '0;
            w_since   = '0;
            w_counted = 1'b0;
        end
    end

    // The first click has priority; the same sampling never also repeats.
    always_comb begin
        w_first  = !w_counted && (CMP_W'(w_held) >= CMP_W'(i_cfg.debounce));
        w_repeat = w_counted && i_repeat_en
                   && (CMP_W'(w_held) >= CMP_W'(i_cfg.hold))
                   && (CMP_W'(w_since) >= CMP_W'(i_cfg.repeat_ival));
        o_click  = i_pressed && (w_first || w_repeat);
    end

    // Next state: a release clears everything.
    always_comb begin
        if (i_pressed) begin
            n_pressed = 1'b1;
            n_counted = w_counted || w_first;
            n_held    = w_held;
            n_since   = (w_first || w_repeat) ? '0 : w_since;
        end else begin
            n_pressed = 1'b0;
            n_counted = 1'b0;
            n_held    = '0;
            n_since   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= 1'b0;
            r_counted <= 1'b0;
            r_held    <= '0;
            r_since   <= '0;
        end else if (i_step) begin
            r_pressed <= n_pressed;
            r_counted <= n_counted;
            r_held    <= n_held;
            r_since   <= n_since;
        end
    end

endmodule

// ===== hdl/button_debounce_autorepeat_unit.sv =====
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_unit
// Debounces active-low button levels and produces click and repeat pulses.
// ----------------------------------------------------------------------------
// One transaction per millisecond tick carries the raw pin levels; each one
// yields exactly one click mask. The unit accepts a new transaction every
// clock cycle while results are taken; each mask is offered once its tick has
// passed through the input register and, with the button cells and sampling
// counter evaluated in a single pass, into the result register. While
// a result waits to be taken the input register can still take one more
// transaction; the next one stalls until the waiting result leaves.
// Configuration writes are always accepted and should be made while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_debounce_autorepeat_unit #(
    parameter int BUTTONS   = 5,
    parameter int TIME_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [BUTTONS-1:0]             i_pin_levels,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [BUTTONS-1:0]             o_click_mask,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bdar_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bdar_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bdar_pkg::*;

    t_cfg               w_cfg;
    t_tick              w_tick;
    logic [BUTTONS-1:0] w_repeat_enable;
    logic [BUTTONS-1:0] w_click;
    logic               w_adv;
    logic               w_step;

    logic               r_in_valid;
    logic [BUTTONS-1:0] r_in_pin;
    logic               r_out_valid;
    logic [BUTTONS-1:0] r_out_click;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    bdar_cfg_regs #(
        .BUTTONS (BUTTONS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr_en         (i_cfg_valid),
        .i_index         (i_cfg_index),
        .i_data          (i_cfg_data),
        .o_cfg           (w_cfg),
        .o_repeat_enable (w_repeat_enable)
    );

    // Pipeline control: the input register moves on when the result slot frees.
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_step     = w_adv && w_tick.sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_pin <= i_pin_levels;
        end
    end

    // Sampling counter.
    bdar_sampler u_sampler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_period (w_cfg.sample_period),
        .o_tick   (w_tick)
    );

    // One tracker per button, updated only on sampling ticks.
    for (genvar g = 0; g < BUTTONS; g++) begin : g_button
        bdar_button #(
            .TIME_BITS (TIME_BITS)
        ) u_button (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_step      (w_step),
            .i_pressed   (!r_in_pin[g]),
            .i_elapsed   (w_tick.elapsed),
            .i_cfg       (w_cfg),
            .i_repeat_en (w_repeat_enable[g]),
            .o_click     (w_click[g])
        );
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_click <= w_tick.sample ? w_click : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_click_mask = r_out_click;

    // Checks on the pipeline and the click logic.
    `BDAR_ASSERT(a_quiet_tick, w_adv && !w_tick.sample |=> r_out_click == '0, "click on a non-sampling tick")
    `BDAR_ASSERT(a_click_pressed, r_in_valid |-> (w_click & r_in_pin) == '0, "click from a released button")
    `BDAR_ASSERT(a_stall_only_full, !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready, "input stalled while a slot is free")

endmodule

// ===== verif/bdar_checker.sv =====
// ----------------------------------------------------------------------------
// bdar_checker
// Watches the tick, click and register channels of the button debounce and
// auto-repeat unit. It keeps its own model of the debounce state, predicts
// one click mask per accepted tick and compares each returned mask with the
// oldest prediction.
// ----------------------------------------------------------------------------
module bdar_checker #(
    parameter int BUTTONS   = 5,
    parameter int TIME_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [BUTTONS-1:0]              i_pin_levels,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [BUTTONS-1:0]              i_click_mask,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [bdar_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bdar_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_compared,
    output int                              o_click_results
);
    import bdar_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // Register copies.
    logic [PERIOD_W-1:0]   sample_period;
    logic [CFG_TIME_W-1:0] debounce_time;
    logic [CFG_TIME_W-1:0] hold_time;
    logic [CFG_TIME_W-1:0] repeat_time;
    logic [BUTTONS-1:0]    repeat_enable;

    // Debounce state per button.
    logic [PERIOD_W-1:0]  ticks_since_sample;
    logic [BUTTONS-1:0]   press_active;
    logic [BUTTONS-1:0]   first_click_given;
    logic [TIME_BITS-1:0] press_duration [BUTTONS];
    logic [TIME_BITS-1:0] since_last_click [BUTTONS];

    // Click masks still owed by the unit, oldest first.
    logic [BUTTONS-1:0] owed_masks [$];

    int failures      = 0;
    int masks_checked = 0;
    int masks_clicked = 0;

    // Saturating add of the ticks since the previous sampling to a press timer.
    function automatic logic [TIME_BITS-1:0] add_ticks(input logic [TIME_BITS-1:0] acc,
                                                       input logic [PERIOD_W-1:0] ticks);
        logic [TIME_BITS:0] total;
        total = {1'b0, acc} + (TIME_BITS+1)'(ticks);
        return total[TIME_BITS] ? {TIME_BITS{1'b1}} : total[TIME_BITS-1:0];
    endfunction

    // Advance the model by one tick and return the clicks that it gives.
    function automatic logic [BUTTONS-1:0] predict_clicks(input logic [BUTTONS-1:0] levels);
        logic [BUTTONS-1:0]  clicks;
        logic [PERIOD_W-1:0] ticks;
        clicks = '0;
        ticks  = (ticks_since_sample < 8'd255) ? ticks_since_sample + 8'd1 : 8'd255;
        if (ticks < sample_period) begin
            ticks_since_sample = ticks;
            return clicks;
        end
        ticks_since_sample = '0;
        for (int b = 0; b < BUTTONS; b++) begin
            if (!levels[b]) begin
                if (!press_active[b]) begin
                    press_active[b]      = 1'b1;
                    first_click_given[b] = 1'b0;
                    press_duration[b]    = '0;
                    since_last_click[b]  = '0;
                end else begin
                    press_duration[b]   = add_ticks(press_duration[b], ticks);
                    since_last_click[b] = add_ticks(since_last_click[b], ticks);
                end
                // The first click of a press never doubles as a repeat.
                if (!first_click_given[b] && press_duration[b] >= debounce_time) begin
                    clicks[b]            = 1'b1;
                    first_click_given[b] = 1'b1;
                    since_last_click[b]  = '0;
                end else if (first_click_given[b] && repeat_enable[b] &&
                             press_duration[b] >= hold_time &&
                             since_last_click[b] >= repeat_time) begin
                    clicks[b]           = 1'b1;
                    since_last_click[b] = '0;
                end
            end else begin
                press_active[b]      = 1'b0;
                first_click_given[b] = 1'b0;
                press_duration[b]    = '0;
                since_last_click[b]  = '0;
            end
        end
        return clicks;
    endfunction

    task automatic report_failure(input string what, input logic [BUTTONS-1:0] want,
                                  input logic [BUTTONS-1:0] got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("[%0t] %s: expected click mask %b, got %b", $time, what, want, got);
    endtask

    // Register writes, result comparison and prediction, in that order.
    always @(posedge i_clk) begin
        logic [BUTTONS-1:0] want;
        if (!i_rst_n) begin
            sample_period      = RST_SAMPLE_PERIOD;
            debounce_time      = RST_DEBOUNCE;
            hold_time          = RST_HOLD;
            repeat_time        = RST_REPEAT;
            repeat_enable      = '0;
            ticks_since_sample = '0;
            press_active       = '0;
            first_click_given  = '0;
            for (int b = 0; b < BUTTONS; b++) begin
                press_duration[b]   = '0;
                since_last_click[b] = '0;
            end
            owed_masks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SAMPLE_PERIOD: sample_period = i_cfg_data[PERIOD_W-1:0];
                    REG_DEBOUNCE:      debounce_time = i_cfg_data[CFG_TIME_W-1:0];
                    REG_HOLD:          hold_time     = i_cfg_data[CFG_TIME_W-1:0];
                    REG_REPEAT:        repeat_time   = i_cfg_data[CFG_TIME_W-1:0];
                    REG_REPEAT_ENABLE: repeat_enable = i_cfg_data[BUTTONS-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (owed_masks.size() == 0) begin
                    report_failure("Result transaction with nothing outstanding", '0,
                                   i_click_mask);
                end else begin
                    want = owed_masks.pop_front();
                    masks_checked++;
                    if (want != '0)
                        masks_clicked++;
                    if (i_click_mask !== want)
                        report_failure("Click mask mismatch", want, i_click_mask);
                end
            end
            if (i_in_valid && i_in_ready)
                owed_masks.push_back(predict_clicks(i_pin_levels));
        end
        o_pending       <= owed_masks.size();
        o_fail_count    <= failures;
        o_compared      <= masks_checked;
        o_click_results <= masks_clicked;
    end

endmodule

// ===== verif/button_debounce_autorepeat_unit_tb.sv =====
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_unit_tb
// Drives tick transactions of raw button levels into the unit under a series
// of register settings: reset values, a directed sequence, random press and
// bounce patterns and a long hold that runs through a series of repeats.
// Both channels stall at random; a separate checker predicts every mask.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat_unit_tb;
    import bdar_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUTTONS   = 5;
    localparam int TIME_BITS = 16;
    localparam int LONG_GAP  = 24;
    // About 1.5k ticks; the limit allows for each one waiting out the longest
    // sender gap and the longest receiver stall.
    localparam int CYCLE_LIMIT = 400_000;
    // Sampling every 8 ticks: enough samplings for the first click and
    // several repeats of the held buttons.
    localparam int HOLD_TICKS = 8 * 12;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  in_valid   = 1'b0;
    logic [BUTTONS-1:0]    pin_levels = '1;
    logic                  out_ready  = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic [BUTTONS-1:0]    click_mask;
    logic                  cfg_ready;

    int fail_count;
    int pending;
    int compared;
    int click_results;

    int ticks_sent       = 0;
    int settings_applied = 0;
    int cycle_count      = 0;
    int burst_left       = 0;
    bit quiet_sender     = 1'b0;

    // State of the random press generator.
    logic [BUTTONS-1:0] steady_level = '1;
    int                 level_left  [BUTTONS];
    int                 bounce_left [BUTTONS];

    always #6 i_clk = ~i_clk;

    button_debounce_autorepeat_unit #(
        .BUTTONS   (BUTTONS),
        .TIME_BITS (TIME_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_pin_levels (pin_levels),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_click_mask (click_mask),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    bdar_checker #(
        .BUTTONS   (BUTTONS),
        .TIME_BITS (TIME_BITS)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_pin_levels    (pin_levels),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_click_mask    (click_mask),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_compared      (compared),
        .o_click_results (click_results)
    );

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("button_debounce_autorepeat_unit_tb NOT OK");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, and now and then a burst with none.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_sender)
            return (r < 95) ? 0 : $urandom_range(1, 3);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            burst_left = $urandom_range(20, 60);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(9, LONG_GAP);
    endfunction

    // Result side: ready runs of random length broken by stalls.
    initial begin
        int run_len;
        int stall_len;
        int r;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(1, 12);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            r = $urandom_range(0, 99);
            stall_len = (r < 50) ? 1 : (r < 90) ? $urandom_range(2, 4) :
                        (r < 97) ? $urandom_range(5, 10) : $urandom_range(11, LONG_GAP);
            out_ready <= 1'b0;
            repeat (stall_len) @(posedge i_clk);
        end
    end

    // Press and release runs of random length with contact bounce at each
    // edge; a share of ticks carry plain random levels instead.
    function automatic logic [BUTTONS-1:0] next_levels(input int scale, input int noise_pct);
        logic [BUTTONS-1:0] levels;
        int                 r;
        if ($urandom_range(0, 99) < noise_pct)
            return BUTTONS'($urandom);
        for (int b = 0; b < BUTTONS; b++) begin
            if (level_left[b] <= 0) begin
                steady_level[b] = ~steady_level[b];
                r = $urandom_range(0, 9);
                level_left[b] = (r < 2) ? $urandom_range(1, 3) :
                                (r < 8) ? $urandom_range(1, scale) :
                                          $urandom_range(scale, 4 * scale);
                bounce_left[b] = $urandom_range(0, 3);
            end
            level_left[b]--;
            if (bounce_left[b] > 0) begin
                levels[b] = 1'($urandom);
                bounce_left[b]--;
            end else begin
                levels[b] = steady_level[b];
            end
        end
        return levels;
    endfunction

    // One tick transaction; valid stays high until it is taken.
    task automatic send_tick(input logic [BUTTONS-1:0] levels);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        pin_levels <= levels;
        do @(posedge i_clk); while (!in_ready);
        ticks_sent++;
    endtask

    // Hold off new ticks until every outstanding mask has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    // Write all registers while the unit is idle, with random bits above the
    // period and enable fields, and optionally write the unused indexes too.
    task automatic apply_settings(input logic [PERIOD_W-1:0] period,
                                  input logic [CFG_TIME_W-1:0] debounce,
                                  input logic [CFG_TIME_W-1:0] hold,
                                  input logic [CFG_TIME_W-1:0] repeat_ival,
                                  input logic [BUTTONS-1:0] enable,
                                  input bit with_unused);
        logic [CFG_DATA_W-1:0] junk;
        drain_results();
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_SAMPLE_PERIOD, {junk[CFG_DATA_W-1:PERIOD_W], period});
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_HOLD, hold);
        write_reg(REG_REPEAT, repeat_ival);
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_REPEAT_ENABLE, {junk[CFG_DATA_W-1:BUTTONS], enable});
        if (with_unused) begin
            for (int k = int'(REG_REPEAT_ENABLE) + 1; k < (1 << CFG_IDX_W); k++)
                write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic send_random_ticks(input int count, input int scale, input int noise_pct);
        for (int n = 0; n < count; n++) begin
            send_tick(next_levels(scale, noise_pct));
            if ($urandom_range(0, 299) == 0)
                drain_results();
        end
    endtask

    // Directed ticks: all released, all pressed, alternate buttons and single buttons.
    logic [BUTTONS-1:0] directed_levels [20] = '{
        5'h1F, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F, 5'h0A, 5'h0A, 5'h0A, 5'h0A,
        5'h15, 5'h15, 5'h15, 5'h1F, 5'h1E, 5'h1D, 5'h1B, 5'h17, 5'h0F, 5'h1F
    };

    initial begin
        int scale;
        for (int b = 0; b < BUTTONS; b++) begin
            level_left[b]  = 0;
            bounce_left[b] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: sampling every 5 ticks, 30 ms debounce, no repeat.
        send_random_ticks(150, 50, 5);

        // Sampling on every tick, zero debounce and repeat, hold of 2, repeat on
        // alternate buttons; unused register indexes are written with junk.
        apply_settings(8'd0, 16'd0, 16'd2, 16'd0, 5'b10101, 1'b1);
        foreach (directed_levels[k])
            send_tick(directed_levels[k]);

        // Random phases, the first two with extreme debounce, hold and repeat.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    apply_settings(8'd1, 16'd0, 16'd0, 16'd0, 5'h1F, 1'b0);
                    scale = 6;
                end
                1: begin
                    apply_settings(8'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'h1F, 1'b0);
                    scale = 20;
                end
                default: begin
                    apply_settings(PERIOD_W'($urandom_range(0, 4)),
                                   CFG_TIME_W'($urandom_range(0, 24)),
                                   CFG_TIME_W'($urandom_range(0, 60)),
                                   CFG_TIME_W'($urandom_range(0, 12)),
                                   BUTTONS'($urandom), 1'b0);
                    scale = $urandom_range(4, 30);
                end
            endcase
            send_random_ticks(150, scale, 8);
        end

        // Long hold at a slow sampling rate: four buttons stay pressed through
        // the first click and a run of repeats, with repeat enabled on all of
        // them. Button 2, whose repeat is off, keeps toggling slowly alongside.
        apply_settings(8'd8, 16'd16, 16'd48, 16'd24, 5'b11011, 1'b0);
        quiet_sender = 1'b1;
        for (int n = 0; n < HOLD_TICKS; n++)
            send_tick(next_levels(2000, 0) & 5'b00100);
        quiet_sender = 1'b0;

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d ticks under %0d register settings after reset values,",
                 ticks_sent, settings_applied);
        $display("with %0d click masks compared, %0d of them carrying clicks.",
                 compared, click_results);
        if (fail_count == 0)
            $display("button_debounce_autorepeat_unit_tb OK");
        else
            $display("button_debounce_autorepeat_unit_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bdar_pkg.sv
hdl/bdar_cfg_regs.sv
hdl/bdar_sampler.sv
hdl/bdar_button.sv
hdl/button_debounce_autorepeat_unit.sv
verif/bdar_checker.sv
verif/button_debounce_autorepeat_unit_tb.sv
